// File: src/fir_filter_direct_form_assert.svh
// Assertion macros for the direct-form FIR filter.
// Included by the top level; no other dependencies.
`ifndef FIR_FILTER_DIRECT_FORM_ASSERT_SVH
`define FIR_FILTER_DIRECT_FORM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Plain property check, disabled while reset is asserted.
`define FIRDF_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication check, disabled while reset is asserted.
`define FIRDF_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`else
`define FIRDF_ASSERT(name, clk, rst_n, prop, msg)
`define FIRDF_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/firdf_pkg.sv
// Shared types, constants and the reset coefficient table of the FIR filter.
// No dependencies; used by the sequencer, the multiply-accumulate unit and the top level.
package firdf_pkg;

	// Default parameter values.
	localparam int TAPS_MAX_DEF     = 512;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEFF_WIDTH_DEF  = 16;

	// Fixed field widths of the stream and configuration beats.
	localparam int TAP_COUNT_W   = 10;
	localparam int COEFF_INDEX_W = 9;
	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 10'd63;

	// Beat kinds carried on the command field.
	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Length of the symmetric bandpass table loaded after reset.
	localparam int BAND_LEN = 63;

	// First half of the symmetric 63-tap bandpass table, Q1.15.
	localparam logic signed [15:0] BAND_HALF [32] = '{
		-16'sd1468, 16'sd1058, 16'sd594, 16'sd287, 16'sd186, 16'sd284, 16'sd485, 16'sd613,
		16'sd495, 16'sd90, -16'sd435, -16'sd762, -16'sd615, 16'sd21, 16'sd821, 16'sd1269,
		16'sd982, 16'sd9, -16'sd1132, -16'sd1721, -16'sd1296, 16'sd1, 16'sd1445, 16'sd2136,
		16'sd1570, 16'sd0, -16'sd1666, -16'sd2413, -16'sd1735, -16'sd2, 16'sd1770, 16'sd2512
	};

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Controls from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic mul_en;
		logic mask;
		logic acc_en;
		logic finish;
	} mac_ctrl_t;

	// Reset coefficient for tap i at 16-bit scale; zero beyond the table.
	function automatic logic [15:0] band_coeff(input logic [31:0] i);
		logic [4:0] sel;
		logic [15:0] val;
		if (i < 32'd32) begin
			sel = i[4:0];
		end else begin
			sel = 5'(32'(BAND_LEN - 1) - i);
		end
		if (i >= 32'(BAND_LEN)) begin
			val = '0;
		end else begin
			val = BAND_HALF[sel];
		end
		return val;
	endfunction

endpackage

// File: src/firdf_ram.sv
// Generic single-port RAM with a registered read, read-before-write.
// No dependencies; holds the coefficient and history stores.
module firdf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle; the read word is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: src/firdf_seq.sv
// Sequencer of the FIR filter: reset table load, tap walk, history ring pointers.
// Depends on firdf_pkg; drives both RAMs and the multiply-accumulate unit.
module firdf_seq #(
	parameter int TAPS_MAX    = firdf_pkg::TAPS_MAX_DEF,
	parameter int COEFF_WIDTH = firdf_pkg::COEFF_WIDTH_DEF,
	localparam int AW = $clog2(TAPS_MAX),
	localparam int KW = $clog2(TAPS_MAX + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [firdf_pkg::TAP_COUNT_W-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_cmd,
	input  logic [firdf_pkg::COEFF_INDEX_W-1:0] coeff_index,
	input  logic [COEFF_WIDTH-1:0]              coeff_value,
	input  logic                                out_free,
	output logic                                coeff_we,
	output logic [AW-1:0]                       coeff_addr,
	output logic [COEFF_WIDTH-1:0]              coeff_wdata,
	output logic                                hist_we,
	output logic [AW-1:0]                       hist_addr,
	output firdf_pkg::mac_ctrl_t                ctrl
);

	localparam logic [AW-1:0] LAST = AW'(TAPS_MAX - 1);

	firdf_pkg::state_t state_q, state_d;
	logic [KW-1:0] k_q, k_next, fill_q, taps_lim;
	logic [AW-1:0] slot_q, ptr_q;
	logic [firdf_pkg::TAP_COUNT_W-1:0] tap_count_q;
	logic rd_s1, mask_s1, acc_s2, issue;
	logic sample_go, load_go;
	logic [COEFF_WIDTH+15:0] init_ext;

	// Tap count clamped to the store depth.
	assign taps_lim = (32'(tap_count_q) > TAPS_MAX) ? KW'(TAPS_MAX) : KW'(tap_count_q);
	assign k_next   = k_q + KW'(1);

	assign sample_go = in_valid && in_ready && (in_cmd == firdf_pkg::CMD_FILTER);
	assign load_go   = in_valid && in_ready && (in_cmd == firdf_pkg::CMD_LOAD) &&
		(32'(coeff_index) < TAPS_MAX);

	// Reset table value rescaled to the coefficient width (floor when narrowing).
	assign init_ext = {firdf_pkg::band_coeff(32'(k_q[AW-1:0])), {COEFF_WIDTH{1'b0}}};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= firdf_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM ports and unit controls.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		coeff_we    = 1'b0;
		coeff_addr  = k_q[AW-1:0];
		coeff_wdata = init_ext[COEFF_WIDTH+15:16];
		hist_we     = 1'b0;
		hist_addr   = slot_q;
		issue       = 1'b0;
		ctrl        = '0;
		ctrl.mul_en = rd_s1;
		ctrl.mask   = mask_s1;
		ctrl.acc_en = acc_s2;
		unique case (state_q)
			firdf_pkg::ST_INIT: begin
				coeff_we = 1'b1;
				if (k_q[AW-1:0] == LAST) begin
					state_d = firdf_pkg::ST_IDLE;
				end
			end
			firdf_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				hist_addr   = ptr_q;
				coeff_addr  = AW'(coeff_index);
				coeff_wdata = coeff_value;
				coeff_we    = load_go;
				if (sample_go) begin
					hist_we    = 1'b1;
					ctrl.clear = 1'b1;
					state_d    = (taps_lim == '0) ? firdf_pkg::ST_DRAIN : firdf_pkg::ST_RUN;
				end
			end
			firdf_pkg::ST_RUN: begin
				issue = 1'b1;
				if (k_next == taps_lim) begin
					state_d = firdf_pkg::ST_DRAIN;
				end
			end
			firdf_pkg::ST_DRAIN: begin
				if (!rd_s1 && !acc_s2 && out_free) begin
					ctrl.finish = 1'b1;
					state_d     = firdf_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Counters, ring pointers, fill count and the read pipeline flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			slot_q      <= '0;
			ptr_q       <= '0;
			fill_q      <= '0;
			tap_count_q <= firdf_pkg::TAP_COUNT_RST;
			rd_s1       <= 1'b0;
			mask_s1     <= 1'b0;
			acc_s2      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				tap_count_q <= cfg_data;
			end
			if (sample_go) begin
				k_q    <= '0;
				slot_q <= ptr_q;
				ptr_q  <= (ptr_q == LAST) ? '0 : ptr_q + AW'(1);
				if (fill_q != KW'(TAPS_MAX)) begin
					fill_q <= fill_q + KW'(1);
				end
			end else if (state_q == firdf_pkg::ST_INIT || issue) begin
				k_q <= k_next;
			end
			if (issue) begin
				slot_q <= (slot_q == '0) ? LAST : slot_q - AW'(1);
			end
			// Slots never written since reset read as zero samples.
			rd_s1   <= issue;
			mask_s1 <= issue && (k_q >= fill_q);
			acc_s2  <= rd_s1;
		end
	end

endmodule

// File: src/firdf_mac.sv
// Shared multiply-accumulate unit with rounding, saturation and the result register.
// Depends on firdf_pkg for the control struct.
module firdf_mac #(
	parameter int TAPS_MAX     = firdf_pkg::TAPS_MAX_DEF,
	parameter int SAMPLE_WIDTH = firdf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEFF_WIDTH  = firdf_pkg::COEFF_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  firdf_pkg::mac_ctrl_t           ctrl,
	input  logic signed [COEFF_WIDTH-1:0]  coeff_rd,
	input  logic signed [SAMPLE_WIDTH-1:0] hist_rd,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           out_free,
	output logic [SAMPLE_WIDTH-1:0]        result
);

	localparam int PW    = SAMPLE_WIDTH + COEFF_WIDTH;
	localparam int ACC_W = PW + $clog2(TAPS_MAX);
	localparam int FB    = COEFF_WIDTH - 1;
	localparam int RW    = ACC_W - FB + 1;

	logic signed [PW-1:0] prod, prod_s2;
	logic [ACC_W-1:0] acc_q;
	logic [RW-1:0] rnd;
	logic ovf;
	logic [SAMPLE_WIDTH-1:0] sat;
	logic out_valid_q;

	// One product per cycle; masked taps contribute zero.
	assign prod = coeff_rd * hist_rd;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= ctrl.mask ? '0 : prod;
		end
	end

	// Exact accumulation of the products.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + {{(ACC_W - PW){prod_s2[PW-1]}}, prod_s2};
		end
	end

	// Round half up to the sample scale, then clamp to the sample range.
	assign rnd = {acc_q[ACC_W-1], acc_q[ACC_W-1:FB]} + RW'(acc_q[FB-1]);
	assign ovf = !(&rnd[RW-1:SAMPLE_WIDTH-1]) && (|rnd[RW-1:SAMPLE_WIDTH-1]);
	assign sat = ovf ? {rnd[RW-1], {(SAMPLE_WIDTH-1){~rnd[RW-1]}}} : rnd[SAMPLE_WIDTH-1:0];

	// Result register: holds a beat until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			result <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

endmodule

// File: src/fir_filter_direct_form.sv
// Direct-form FIR filter with one shared multiply-accumulate unit, top level.
// Depends on firdf_pkg, firdf_ram, firdf_seq, firdf_mac and the assertion header.
//
// A sample beat (s_tuser 0) enters the history ring; the block then walks tap_count
// taps (a tap count above TAPS_MAX counts as TAPS_MAX, and a tap count of zero gives
// a zero output) and its output beat becomes valid once the result register is free.
// The block accepts nothing else meanwhile, so it cannot take a new sample before it
// is through with the last one. The walk is done by the single multiplier, which
// takes one coefficient and one past sample per cycle from two single-port RAMs; each
// product passes the RAM read register and the product register before it is
// accumulated, then rounded and saturated. A coefficient beat (s_tuser 1) is written
// into the coefficient RAM as it is taken and yields no output. After reset the block loads
// the 63-tap bandpass table into all TAPS_MAX coefficient RAM entries (512 by default);
// s_tready stays low during that sweep, while configuration writes are taken at any time.
module fir_filter_direct_form #(
	parameter int TAPS_MAX     = firdf_pkg::TAPS_MAX_DEF,
	parameter int SAMPLE_WIDTH = firdf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEFF_WIDTH  = firdf_pkg::COEFF_WIDTH_DEF,
	localparam int IN_W  = ((SAMPLE_WIDTH + firdf_pkg::COEFF_INDEX_W + COEFF_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: tap_count.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [firdf_pkg::TAP_COUNT_W-1:0] cfg_data,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_W-1:0]                   s_tdata,  // sample, coeff_index, coeff_value
	input  logic                              s_tuser,  // cmd
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_W-1:0]                  m_tdata   // filtered_sample
);

	localparam int AW = $clog2(TAPS_MAX);
	localparam int IXW = firdf_pkg::COEFF_INDEX_W;

	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic [IXW-1:0] coeff_index;
	logic [COEFF_WIDTH-1:0] coeff_value;
	logic coeff_we, hist_we, out_free;
	logic [AW-1:0] coeff_addr, hist_addr;
	logic [COEFF_WIDTH-1:0] coeff_wdata, coeff_rd;
	logic [SAMPLE_WIDTH-1:0] hist_rd, result;
	firdf_pkg::mac_ctrl_t mac_ctrl;

	// Unpack the input beat.
	assign sample      = s_tdata[SAMPLE_WIDTH-1:0];
	assign coeff_index = s_tdata[SAMPLE_WIDTH+IXW-1:SAMPLE_WIDTH];
	assign coeff_value = s_tdata[SAMPLE_WIDTH+IXW+COEFF_WIDTH-1:SAMPLE_WIDTH+IXW];

	assign cfg_ready = 1'b1;
	assign m_tdata   = OUT_W'(result);

	// Sequencer.
	firdf_seq #(
		.TAPS_MAX   (TAPS_MAX),
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.out_free   (out_free),
		.coeff_we   (coeff_we),
		.coeff_addr (coeff_addr),
		.coeff_wdata(coeff_wdata),
		.hist_we    (hist_we),
		.hist_addr  (hist_addr),
		.ctrl       (mac_ctrl)
	);

	// Coefficient store.
	firdf_ram #(
		.WIDTH(COEFF_WIDTH),
		.DEPTH(TAPS_MAX)
	) u_coeff_ram (
		.clk  (clk),
		.we   (coeff_we),
		.addr (coeff_addr),
		.wdata(coeff_wdata),
		.rdata(coeff_rd)
	);

	// Sample history ring.
	firdf_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(TAPS_MAX)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.addr (hist_addr),
		.wdata(sample),
		.rdata(hist_rd)
	);

	// Shared multiply-accumulate unit and result register.
	firdf_mac #(
		.TAPS_MAX    (TAPS_MAX),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.coeff_rd (coeff_rd),
		.hist_rd  (hist_rd),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_free (out_free),
		.result   (result)
	);

	// Checks on the sequencer and unit working together.
`include "fir_filter_direct_form_assert.svh"
`FIRDF_ASSERT_IMPL(a_finish_free, clk, arst_n, mac_ctrl.finish, !m_tvalid || m_tready, "result overwritten")
`FIRDF_ASSERT_IMPL(a_acc_no_clear, clk, arst_n, mac_ctrl.acc_en, !mac_ctrl.clear, "clear during accumulate")
`FIRDF_ASSERT(a_accept_pipe_idle, clk, arst_n, !(s_tvalid && s_tready) || (!mac_ctrl.mul_en && !mac_ctrl.acc_en), "beat taken while busy")

endmodule
